// ----- design/sph6_pkg.sv -----
// Shared types, constants and the saturation helper for the poly6 kernel unit.
// Used by sph6_datapath and sph_poly6_kernel_eval_unit; depends on nothing.
`default_nettype none

package sph6_pkg;

    localparam int unsigned CFG_W      = 32;
    localparam int unsigned PIPE_DEPTH = 7;
    localparam logic [16:0] ONE_Q16    = 17'h1_0000;

    typedef enum logic [1:0] {
        REG_RADIUS_SQ     = 2'd0,
        REG_INV_RADIUS_SQ = 2'd1,
        REG_VALUE_COEF    = 2'd2,
        REG_DERIV_COEF    = 2'd3
    } sph6_reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] radius_sq;
        logic [CFG_W-1:0] inv_radius_sq;
        logic [CFG_W-1:0] value_coef;
        logic [CFG_W-1:0] deriv_coef;
    } sph6_cfg_t;

    typedef struct packed {
        logic [2:0][31:0] grad;
        logic [31:0]      second_deriv;
        logic [31:0]      first_deriv;
        logic [30:0]      kernel_value;
    } sph6_result_t;

    // Clamp a sign and magnitude to the int32 range.
    function automatic logic [31:0] sat_s32(input logic neg, input logic [38:0] mag);
        logic [31:0] r;
        if (neg)
        begin
            if (mag > 39'h00_8000_0000)
                r = 32'h8000_0000;
            else
                r = ~mag[31:0] + 32'd1;
        end
        else
        begin
            if (mag > 39'h00_7FFF_FFFF)
                r = 32'h7FFF_FFFF;
            else
                r = mag[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/sph6_datapath.sv -----
// Seven-stage arithmetic pipeline for the poly6 kernel, its derivatives and gradient.
// Depends on sph6_pkg for the config and result structs and the saturation helper.
`default_nettype none

module sph6_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [15:0]           distance,
    input  wire logic [2:0][15:0]      dir,
    input  wire sph6_pkg::sph6_cfg_t   cfg,
    output logic                       out_vld,
    output sph6_pkg::sph6_result_t     res
);

    localparam int unsigned DEPTH = sph6_pkg::PIPE_DEPTH;

    logic [DEPTH-1:0] vld_reg, vld_next;

    // stage 1
    logic [31:0]      d2_reg, d2_next;
    logic [2:0][15:0] dabs_next;
    logic [2:0]       dneg_next;
    // stage 2
    logic [63:0]      t_prod;
    logic [16:0]      t_reg, t_next;
    logic             inside_next;
    // stage 3
    logic [16:0]      u_cur;
    logic [33:0]      uu_prod;
    logic [48:0]      p_prod;
    logic [18:0]      t5;
    logic [16:0]      u_reg, u2_reg, u2_next;
    logic [32:0]      p_reg, p_next;
    logic [18:0]      sabs_reg, sabs_next;
    logic             sneg3_reg, sneg3_next;
    // stage 4
    logic [33:0]      u3_prod;
    logic [51:0]      s_prod;
    logic [16:0]      u3_reg, u3_next;
    logic [48:0]      dcu2_reg, dcu2_next;
    logic [35:0]      smag_reg, smag_next;
    logic             sneg4_reg;
    // stage 5
    logic [48:0]      v_prod;
    logic [64:0]      m_prod;
    logic [30:0]      kval5_reg, kval5_next;
    logic [36:0]      m1_reg, m1_next;
    logic [31:0]      sd5_reg, sd5_next;
    // stage 6
    logic [2:0][52:0] g_prod;
    logic [30:0]      kval6_reg;
    logic [31:0]      sd6_reg;
    logic [31:0]      fd_reg, fd_next;
    logic [2:0][38:0] gmag_reg, gmag_next;
    // stage 7
    sph6_pkg::sph6_result_t res_reg, res_next;

    // shift lines
    logic [15:0]      dist_reg   [1:4];
    logic [2:0][15:0] dabs_reg   [1:5];
    logic [2:0]       dneg_reg   [1:6];
    logic             inside_reg [2:6];

    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], in_vld};

        d2_next = {16'd0, distance} * {16'd0, distance};
        for (int c = 0; c < 3; c++)
        begin
            dneg_next[c] = dir[c][15];
            dabs_next[c] = dir[c][15] ? (~dir[c] + 16'd1) : dir[c];
        end

        t_prod      = {32'd0, d2_reg} * {32'd0, cfg.inv_radius_sq};
        t_next      = (t_prod[63:24] > {23'd0, sph6_pkg::ONE_Q16}) ?
                      sph6_pkg::ONE_Q16 : t_prod[40:24];
        inside_next = d2_reg < cfg.radius_sq;

        u_cur   = sph6_pkg::ONE_Q16 - t_reg;
        uu_prod = {17'd0, u_cur} * {17'd0, u_cur};
        u2_next = uu_prod[32:16];
        p_prod  = {17'd0, cfg.deriv_coef} * {32'd0, u_cur};
        p_next  = p_prod[48:16];
        t5      = ({2'd0, t_reg} << 2) + {2'd0, t_reg};
        if (t5 >= {2'd0, sph6_pkg::ONE_Q16})
        begin
            sneg3_next = 1'b0;
            sabs_next  = t5 - {2'd0, sph6_pkg::ONE_Q16};
        end
        else
        begin
            sneg3_next = 1'b1;
            sabs_next  = {2'd0, sph6_pkg::ONE_Q16} - t5;
        end

        u3_prod   = {17'd0, u2_reg} * {17'd0, u_reg};
        u3_next   = u3_prod[32:16];
        dcu2_next = {17'd0, cfg.deriv_coef} * {32'd0, u2_reg};
        s_prod    = {19'd0, p_reg} * {33'd0, sabs_reg};
        smag_next = s_prod[51:16];

        v_prod     = {17'd0, cfg.value_coef} * {32'd0, u3_reg};
        kval5_next = (v_prod[48:47] != 2'd0) ? 31'h7FFF_FFFF : v_prod[46:16];
        m_prod     = {16'd0, dcu2_reg} * {49'd0, dist_reg[4]};
        m1_next    = m_prod[64:28];
        sd5_next   = sph6_pkg::sat_s32(sneg4_reg && (smag_reg != 36'd0), {3'd0, smag_reg});

        fd_next = (m1_reg > 37'h0_8000_0000) ? 32'h8000_0000 : (~m1_reg[31:0] + 32'd1);
        for (int c = 0; c < 3; c++)
        begin
            g_prod[c]    = {16'd0, m1_reg} * {37'd0, dabs_reg[5][c]};
            gmag_next[c] = g_prod[c][52:14];
        end

        res_next = '0;
        if (inside_reg[6])
        begin
            res_next.kernel_value = kval6_reg;
            res_next.first_deriv  = fd_reg;
            res_next.second_deriv = sd6_reg;
            for (int c = 0; c < 3; c++)
                res_next.grad[c] = sph6_pkg::sat_s32(dneg_reg[6][c] && (gmag_reg[c] != 39'd0),
                                                     gmag_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg    <= d2_next;
            t_reg     <= t_next;
            u_reg     <= u_cur;
            u2_reg    <= u2_next;
            p_reg     <= p_next;
            sabs_reg  <= sabs_next;
            sneg3_reg <= sneg3_next;
            u3_reg    <= u3_next;
            dcu2_reg  <= dcu2_next;
            smag_reg  <= smag_next;
            sneg4_reg <= sneg3_reg;
            kval5_reg <= kval5_next;
            m1_reg    <= m1_next;
            sd5_reg   <= sd5_next;
            kval6_reg <= kval5_reg;
            sd6_reg   <= sd5_reg;
            fd_reg    <= fd_next;
            gmag_reg  <= gmag_next;
            res_reg   <= res_next;

            dist_reg[1]   <= distance;
            dabs_reg[1]   <= dabs_next;
            dneg_reg[1]   <= dneg_next;
            inside_reg[2] <= inside_next;
            for (int i = 2; i <= 4; i++)
                dist_reg[i] <= dist_reg[i-1];
            for (int i = 2; i <= 5; i++)
                dabs_reg[i] <= dabs_reg[i-1];
            for (int i = 2; i <= 6; i++)
                dneg_reg[i] <= dneg_reg[i-1];
            for (int i = 3; i <= 6; i++)
                inside_reg[i] <= inside_reg[i-1];
        end
    end

    assign out_vld = vld_reg[DEPTH-1];
    assign res     = res_reg;

    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_enter : assert property (@(posedge clk) disable iff (!rst_n)
        en |=> vld_reg[0] == $past(in_vld))
        else $error("accepted word did not enter the first stage");

    a_deriv_sign : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld |-> (res.first_deriv[31] || res.first_deriv == 32'd0))
        else $error("first derivative is positive");

    a_grad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld && res.first_deriv == 32'd0) |-> res.grad == '0)
        else $error("gradient nonzero with zero first derivative");

endmodule

`default_nettype wire

// ----- design/sph_poly6_kernel_eval_unit.sv -----
// Poly6 SPH kernel unit: fixed-point W, W', W'' and gradient for one distance per word.
// Top level; holds the coefficient registers and the stream handshake.
// Depends on sph6_pkg and sph6_datapath.
//
// One word is taken every cycle while the output side keeps up: the seven-stage
// pipeline in sph6_datapath advances as a whole and freezes in place while the output
// word waits to be taken. Coefficients (radius squared Q8.24, its reciprocal and the two
// scale factors Q16.16) must be written through the cfg port while the stream is idle;
// the block itself does not enforce this. Outputs are zero at or beyond the radius and
// saturate to their ranges.
`default_nettype none

module sph_poly6_kernel_eval_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,  // distance, dir_x, dir_y, dir_z
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [191:0]      m_axis_tdata   // kernel_value, first_deriv, second_deriv,
                                             // grad_x, grad_y, grad_z, zero pad
);

    sph6_pkg::sph6_cfg_t    cfg_reg, cfg_next;
    sph6_pkg::sph6_result_t res;
    logic                   en;
    logic [2:0][15:0]       dir;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sph6_pkg::sph6_reg_idx_t'(cfg_index))
                sph6_pkg::REG_RADIUS_SQ:     cfg_next.radius_sq     = cfg_wdata;
                sph6_pkg::REG_INV_RADIUS_SQ: cfg_next.inv_radius_sq = cfg_wdata;
                sph6_pkg::REG_VALUE_COEF:    cfg_next.value_coef    = cfg_wdata;
                sph6_pkg::REG_DERIV_COEF:    cfg_next.deriv_coef    = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // advance whenever the output word is absent or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign dir[0] = s_axis_tdata[31:16];
    assign dir[1] = s_axis_tdata[47:32];
    assign dir[2] = s_axis_tdata[63:48];

    sph6_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_axis_tvalid),
        .distance (s_axis_tdata[15:0]),
        .dir      (dir),
        .cfg      (cfg_reg),
        .out_vld  (m_axis_tvalid),
        .res      (res)
    );

    assign m_axis_tdata = {1'b0, res.grad[2], res.grad[1], res.grad[0],
                           res.second_deriv, res.first_deriv, res.kernel_value};

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Stream-level checks for the poly6 SPH kernel unit: random and directed distance words
// are compared against an in-bench fixed-point kernel evaluation, result by result.
// Depends on sph6_pkg and sph_poly6_kernel_eval_unit.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam real PI = 3.14159265358979;

    typedef struct packed {
        logic [2:0][15:0] dir;
        logic [15:0]      distance;
    } dist_word_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_we        = 1'b0;
    logic [1:0]   cfg_index     = '0;
    logic [31:0]  cfg_wdata     = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;  // distance, dir_x, dir_y, dir_z
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;        // kernel_value, first_deriv, second_deriv,
                                       // grad_x, grad_y, grad_z, zero pad

    sph6_pkg::sph6_cfg_t    coef_regs = '0;
    logic [63:0]            words_pending[$];
    sph6_pkg::sph6_result_t results_due[$];
    int                     words_sent = 0;
    int                     src_wait   = 0;
    int                     sink_wait  = 0;
    int                     mismatches = 0;
    bit                     burst_mode = 1'b0;
    logic                   hold_off   = 1'b0;

    sph_poly6_kernel_eval_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] clamp_to_s32(input logic neg, input logic [63:0] mag);
        if (neg)
            return (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic sph6_pkg::sph6_result_t poly6_eval(input sph6_pkg::sph6_cfg_t c,
                                                          input dist_word_t w);
        sph6_pkg::sph6_result_t r;
        logic [63:0]  sep, d2, t, u, u2, u3, val, m1, p, sabs, smag, dabs, g;
        logic         sneg;
        r = '0;
        sep = {48'd0, w.distance};
        d2 = sep * sep;
        if (d2 < {32'd0, c.radius_sq})
        begin
            t = (d2 * {32'd0, c.inv_radius_sq}) >> 24;
            if (t > 64'd65536)
                t = 64'd65536;
            u = 64'd65536 - t;
            u2 = (u * u) >> 16;
            u3 = (u2 * u) >> 16;
            val = ({32'd0, c.value_coef} * u3) >> 16;
            r.kernel_value = (val > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : val[30:0];
            m1 = ({32'd0, c.deriv_coef} * u2 * sep) >> 28;
            r.first_deriv = clamp_to_s32(1'b1, m1);
            p = ({32'd0, c.deriv_coef} * u) >> 16;
            sneg = (64'd5 * t) < 64'd65536;
            sabs = sneg ? (64'd65536 - 64'd5 * t) : (64'd5 * t - 64'd65536);
            smag = (p * sabs) >> 16;
            r.second_deriv = clamp_to_s32(sneg, smag);
            for (int k = 0; k < 3; k++)
            begin
                dabs = w.dir[k][15] ? (64'h1_0000 - {48'd0, w.dir[k]}) : {48'd0, w.dir[k]};
                g = (m1 * dabs) >> 14;
                r.grad[k] = clamp_to_s32(w.dir[k][15], g);
            end
        end
        return r;
    endfunction

    function automatic int draw_wait();
        if (burst_mode)
            return 0;
        return ($urandom_range(0, 1) != 0) ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [31:0] real_to_u32(input real x);
        if (x >= 2147483647.0)
            return 32'h7FFF_FFFF;
        return $rtoi(x);
    endfunction

    function automatic sph6_pkg::sph6_cfg_t cfg_for_radius(input real h, input real inv_scale);
        sph6_pkg::sph6_cfg_t c;
        c.radius_sq     = real_to_u32(h * h * 16777216.0);
        c.inv_radius_sq = real_to_u32(inv_scale * 65536.0 / (h * h));
        c.value_coef    = real_to_u32(315.0 / (64.0 * PI * h * h * h) * 65536.0);
        c.deriv_coef    = real_to_u32(945.0 / (32.0 * PI * h * h * h * h * h) * 65536.0);
        return c;
    endfunction

    function automatic logic [63:0] make_word(input int sep, input int dx, input int dy,
                                              input int dz);
        return {16'(dz), 16'(dy), 16'(dx), 16'(sep)};
    endfunction

    task automatic queue_word(input int sep, input int dx, input int dy, input int dz);
        words_pending = {words_pending, make_word(sep, dx, dy, dz)};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s got %08h want %08h", $time, what, got, want);
    endtask

    task automatic write_reg(input sph6_pkg::sph6_reg_idx_t idx, input logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        unique case (idx)
            sph6_pkg::REG_RADIUS_SQ:     coef_regs.radius_sq     = v;
            sph6_pkg::REG_INV_RADIUS_SQ: coef_regs.inv_radius_sq = v;
            sph6_pkg::REG_VALUE_COEF:    coef_regs.value_coef    = v;
            sph6_pkg::REG_DERIV_COEF:    coef_regs.deriv_coef    = v;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cfg(input sph6_pkg::sph6_cfg_t c);
        write_reg(sph6_pkg::REG_RADIUS_SQ, c.radius_sq);
        write_reg(sph6_pkg::REG_INV_RADIUS_SQ, c.inv_radius_sq);
        write_reg(sph6_pkg::REG_VALUE_COEF, c.value_coef);
        write_reg(sph6_pkg::REG_DERIV_COEF, c.deriv_coef);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (words_pending.size() != 0 || s_axis_tvalid || results_due.size() != 0);
    endtask

    task automatic queue_random(input int n);
        int dmax, sep;
        int d[3];
        dmax = $rtoi($sqrt(real'(coef_regs.radius_sq)));
        dmax = dmax + dmax / 16 + 2;
        if (dmax > 65535)
            dmax = 65535;
        for (int i = 0; i < n; i++)
        begin
            sep = ($urandom_range(0, 7) != 0) ? int'($urandom_range(0, dmax))
                                              : int'($urandom_range(0, 65535));
            for (int k = 0; k < 3; k++)
                d[k] = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 32768)) - 16384
                                                   : int'($urandom_range(0, 65535));
            queue_word(sep, d[0], d[1], d[2]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_wait      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                results_due = {results_due, poly6_eval(coef_regs, s_axis_tdata)};
                words_sent <= words_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_wait != 0)
                begin
                    src_wait      <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (words_pending.size() != 0)
                begin
                    s_axis_tdata  <= words_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    src_wait      <= draw_wait();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_check
        sph6_pkg::sph6_result_t got, want;
        int                     w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end
        else
        begin
            w = sink_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[190:0];
                if (results_due.size() == 0)
                begin
                    report_mismatch("result word with nothing due, first_deriv",
                                    got.first_deriv, '0);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.kernel_value != want.kernel_value)
                        report_mismatch("kernel_value", {1'b0, got.kernel_value},
                                        {1'b0, want.kernel_value});
                    if (got.first_deriv != want.first_deriv)
                        report_mismatch("first_deriv", got.first_deriv, want.first_deriv);
                    if (got.second_deriv != want.second_deriv)
                        report_mismatch("second_deriv", got.second_deriv, want.second_deriv);
                    for (int k = 0; k < 3; k++)
                        if (got.grad[k] != want.grad[k])
                            report_mismatch($sformatf("grad[%0d]", k), got.grad[k],
                                            want.grad[k]);
                end
                w = draw_wait();
            end
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                sink_wait     <= w;
            end
            else if (w != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait     <= w - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_wait     <= 0;
            end
        end
    end

    // Hold the output side once, during the first burst phase, after forty words have been sent.
    initial
    begin : receiver_hold
        int hold_base;
        wait (burst_mode);
        hold_base = words_sent;
        wait (words_sent >= hold_base + 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        sph6_pkg::sph6_cfg_t phase_cfg[8];
        phase_cfg[0] = cfg_for_radius(1.0, 1.0);
        phase_cfg[1] = cfg_for_radius(0.5, 1.0);
        phase_cfg[2] = cfg_for_radius(3.9, 1.0);
        phase_cfg[3] = cfg_for_radius(0.25, 1.0);
        phase_cfg[4] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        phase_cfg[5] = cfg_for_radius(1.0, 1.08);
        phase_cfg[6] = '{32'hFFFF_FFFF, 32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        phase_cfg[7] = '{$urandom, $urandom, $urandom, $urandom};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: radius zero, everything lands outside
        queue_word(0, 16384, 0, 0);
        queue_word(100, -16384, 8192, 4096);
        queue_word(65535, -32768, 32767, -1);
        wait_idle();

        load_cfg(phase_cfg[0]);
        queue_word(0, 16384, 0, 0);
        queue_word(0, -16384, -32768, 32767);
        queue_word(1, 0, 16384, -16384);
        queue_word(1000, 11585, 11585, 0);
        queue_word(1831, -11585, 0, 11585);
        queue_word(1832, 9459, -9459, 9459);
        queue_word(2048, -16384, 16384, 8192);
        queue_word(3000, -32768, -32768, -32768);
        queue_word(4095, 16384, 16384, 16384);
        queue_word(4095, 32767, -32767, -32768);
        queue_word(4096, 16384, -16384, 0);
        queue_word(4097, -16384, 0, 16384);
        queue_word(65535, -32768, 32767, 16384);
        queue_word(32768, 65535, 0, 1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            burst_mode = (ph % 2) != 0;
            load_cfg(phase_cfg[ph]);
            queue_random(242);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
